// ===== src/windowed_intrusion_damage_scorer_core_defines.svh =====
// ============================================================================
// Assertion macros for the windowed intrusion damage scorer
// Concurrent checks that compile away when SYNTH is defined.
// ============================================================================
`ifndef WINDOWED_INTRUSION_DAMAGE_SCORER_CORE_DEFINES_SVH
`define WINDOWED_INTRUSION_DAMAGE_SCORER_CORE_DEFINES_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define WIDS_ASSERT_HOLD(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define WIDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define WIDS_ASSERT_HOLD(lbl, clk, rstn, ante, cons)
`define WIDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== src/wids_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Windowed intrusion damage scorer package
// Widths, scoring constants, register codes and shared types.
// ============================================================================
package wids_pkg;

	localparam int WINDOW_DEPTH = 16;

	localparam int SLOT_W    = $clog2(WINDOW_DEPTH);
	localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
	localparam int DIST_W    = 16;
	localparam int DTOT_W    = $clog2(65535 * WINDOW_DEPTH + 1);
	localparam int SCORE_W   = 14;
	localparam int STAMP_W   = 32;
	localparam int NEAR_W    = $clog2(1000 * WINDOW_DEPTH + 1);
	localparam int NUM_W     = $clog2(20001 * WINDOW_DEPTH + 1);
	localparam int DEN_W     = CNT_W + 1;
	localparam int DIV_CNT_W = $clog2(NUM_W);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam int VIB_WEIGHT      = 4000;
	localparam int PRES_WEIGHT     = 3000;
	localparam int NEAR_WEIGHT     = 3;
	localparam int NEAR_MM         = 1000;
	localparam int MIN_COUNT       = 5;
	localparam int SCORE_MAX       = 10000;
	localparam int DROP_LIMIT      = 2000;
	localparam int DROP_FLOOR      = 3000;
	localparam int DROP_STEP       = 500;
	localparam int INTERVAL_RESET  = 1000;
	localparam int THRESHOLD_RESET = 7000;

	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [DIST_W-1:0]    dist_t;
	typedef logic [DTOT_W-1:0]    dtot_t;
	typedef logic [SCORE_W-1:0]   score_t;
	typedef logic [STAMP_W-1:0]   stamp_t;
	typedef logic [NEAR_W-1:0]    near_t;
	typedef logic [NUM_W-1:0]     num_t;
	typedef logic [DEN_W-1:0]     den_t;
	typedef logic [DIV_CNT_W-1:0] div_cnt_t;
	typedef logic [QPTR_W-1:0]    qptr_t;
	typedef logic [QCNT_W-1:0]    qcnt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INTERVAL  = 0,
		CFG_THRESHOLD = 1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_COUNT,
		BK_LOAD,
		BK_DIV,
		BK_SCORE
	} back_state_t;

	typedef struct packed {
		logic  accepted;
		logic  vibration;
		logic  presence;
		dist_t distance_mm;
	} item_t;

	typedef struct packed {
		logic  vibration;
		logic  presence;
		dist_t distance_mm;
	} ring_t;

endpackage

// ===== src/wids_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Windowed intrusion damage scorer channel interfaces
// Sample input, result output and configuration write channels.
// ============================================================================
interface wids_sample_if;
	logic            valid;
	logic            ready;
	wids_pkg::stamp_t now_ms;
	logic            vibration;
	logic            presence;
	wids_pkg::dist_t distance_mm;

	modport source(output valid, output now_ms, output vibration, output presence,
		output distance_mm, input ready);
	modport sink(input valid, input now_ms, input vibration, input presence,
		input distance_mm, output ready);
endinterface

interface wids_result_if;
	logic             valid;
	logic             ready;
	logic             accepted;
	wids_pkg::score_t damage_score;
	logic             damage_likely;

	modport source(output valid, output accepted, output damage_score,
		output damage_likely, input ready);
	modport sink(input valid, input accepted, input damage_score,
		input damage_likely, output ready);
endinterface

interface wids_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [wids_pkg::CFG_IDX_W-1:0]      index;
	logic [wids_pkg::CFG_DATA_W-1:0]     data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== src/wids_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Sample classifier
// Checks each sample against the minimum interval and tags it for the back end.
// ============================================================================
module wids_front (
	input  logic              clk,
	input  logic              arst_n,
	wids_sample_if.sink       sample,
	input  wids_pkg::stamp_t  interval,
	output wids_pkg::item_t   push_item,
	output logic              push_valid,
	input  logic              push_ready
);

	wids_pkg::stamp_t last_q;
	wids_pkg::stamp_t elapsed;
	logic             pass;

	assign elapsed = sample.now_ms - last_q;
	assign pass    = elapsed >= interval;

	assign sample.ready = push_ready;
	assign push_valid   = sample.valid;

	always_comb begin
		push_item.accepted    = pass;
		push_item.vibration   = sample.vibration;
		push_item.presence    = sample.presence;
		push_item.distance_mm = sample.distance_mm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (sample.valid && push_ready && pass) begin
			last_q <= sample.now_ms;
		end
	end

endmodule

// ===== src/wids_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Classified sample queue
// Short first-in first-out buffer between the classifier and the scorer.
// ============================================================================
`include "windowed_intrusion_damage_scorer_core_defines.svh"

module wids_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  wids_pkg::item_t push_item,
	input  logic            push_valid,
	output logic            push_ready,
	output wids_pkg::item_t pop_item,
	output logic            pop_valid,
	input  logic            pop_ready
);

	wids_pkg::item_t store_q [wids_pkg::QUEUE_DEPTH];
	wids_pkg::qptr_t wr_ptr_q;
	wids_pkg::qptr_t rd_ptr_q;
	wids_pkg::qcnt_t count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != wids_pkg::qcnt_t'(wids_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = store_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == wids_pkg::qptr_t'(wids_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (do_pop) begin
				if (rd_ptr_q == wids_pkg::qptr_t'(wids_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`WIDS_ASSERT_HOLD(a_queue_bound, clk, arst_n, 1'b1, count_q <= wids_pkg::QUEUE_DEPTH)

endmodule

// ===== src/wids_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Window scorer
// Updates the sample window and totals, divides out the fresh score with a
// bit-serial divider, applies the decay rule and holds the result.
// ============================================================================
`include "windowed_intrusion_damage_scorer_core_defines.svh"

module wids_back (
	input  logic             clk,
	input  logic             arst_n,
	input  wids_pkg::item_t  pop_item,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  wids_pkg::score_t threshold,
	wids_result_if.source    result
);

	wids_pkg::back_state_t state_q;
	wids_pkg::back_state_t state_d;

	wids_pkg::ring_t  ring_mem [wids_pkg::WINDOW_DEPTH];
	wids_pkg::ring_t  old_q;
	wids_pkg::ring_t  new_entry;
	logic             ring_re;
	logic             ring_we;

	wids_pkg::item_t  item_q;
	wids_pkg::slot_t  slot_q;
	logic             full_q;
	wids_pkg::cnt_t   vtot_q;
	wids_pkg::cnt_t   ptot_q;
	wids_pkg::dtot_t  dtot_q;
	wids_pkg::score_t score_q;

	wids_pkg::num_t   term_q;
	wids_pkg::near_t  diff_q;
	wids_pkg::num_t   quo_q;
	wids_pkg::den_t   rem_q;
	wids_pkg::den_t   den_q;
	wids_pkg::div_cnt_t dcnt_q;

	logic             res_valid_q;
	logic             res_acc_q;
	wids_pkg::score_t res_score_q;
	logic             res_likely_q;

	wids_pkg::cnt_t   count_c;
	wids_pkg::near_t  near_c;
	wids_pkg::num_t   num_c;
	logic [wids_pkg::DEN_W:0] trial_c;
	logic             ge_c;
	logic [wids_pkg::SCORE_W:0] avg_c;
	wids_pkg::num_t   upd_c;
	wids_pkg::score_t score_new;

	assign result.valid         = res_valid_q;
	assign result.accepted      = res_acc_q;
	assign result.damage_score  = res_score_q;
	assign result.damage_likely = res_likely_q;

	assign count_c = full_q ? wids_pkg::cnt_t'(wids_pkg::WINDOW_DEPTH) : wids_pkg::cnt_t'(slot_q);
	assign near_c  = wids_pkg::near_t'(count_c) * wids_pkg::near_t'(wids_pkg::NEAR_MM);
	assign num_c   = term_q + wids_pkg::num_t'(wids_pkg::NEAR_WEIGHT) * wids_pkg::num_t'(diff_q);
	assign trial_c = {rem_q, quo_q[wids_pkg::NUM_W-1]};
	assign ge_c    = trial_c >= {1'b0, den_q};

	always_comb begin
		new_entry.vibration   = item_q.vibration;
		new_entry.presence    = item_q.presence;
		new_entry.distance_mm = item_q.distance_mm;
	end

	always_comb begin
		avg_c = ({1'b0, score_q} + {1'b0, quo_q[wids_pkg::SCORE_W-1:0]} + 1'b1) >> 1;
		if (quo_q < wids_pkg::num_t'(score_q)) begin
			upd_c = wids_pkg::num_t'(avg_c);
			if (quo_q < wids_pkg::num_t'(wids_pkg::DROP_LIMIT)
					&& upd_c > wids_pkg::num_t'(wids_pkg::DROP_FLOOR)) begin
				upd_c = upd_c - wids_pkg::num_t'(wids_pkg::DROP_STEP);
			end
		end else begin
			upd_c = quo_q;
		end
		if (upd_c > wids_pkg::num_t'(wids_pkg::SCORE_MAX)) begin
			upd_c = wids_pkg::num_t'(wids_pkg::SCORE_MAX);
		end
		score_new = wids_pkg::score_t'(upd_c);
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		ring_re   = 1'b0;
		ring_we   = 1'b0;
		case (state_q)
			wids_pkg::BK_IDLE: begin
				if (pop_valid && !res_valid_q) begin
					pop_ready = 1'b1;
					if (pop_item.accepted) begin
						ring_re = 1'b1;
						state_d = wids_pkg::BK_READ;
					end
				end
			end
			wids_pkg::BK_READ: begin
				ring_we = 1'b1;
				state_d = wids_pkg::BK_COUNT;
			end
			wids_pkg::BK_COUNT: begin
				if (count_c < wids_pkg::MIN_COUNT) begin
					state_d = wids_pkg::BK_IDLE;
				end else begin
					state_d = wids_pkg::BK_LOAD;
				end
			end
			wids_pkg::BK_LOAD: begin
				state_d = wids_pkg::BK_DIV;
			end
			wids_pkg::BK_DIV: begin
				if (dcnt_q == '0) begin
					state_d = wids_pkg::BK_SCORE;
				end
			end
			wids_pkg::BK_SCORE: begin
				state_d = wids_pkg::BK_IDLE;
			end
			default: begin
				state_d = wids_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wids_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[slot_q] <= new_entry;
		end
		if (ring_re) begin
			old_q <= ring_mem[slot_q];
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			item_q <= pop_item;
		end
		case (state_q)
			wids_pkg::BK_COUNT: begin
				term_q <= wids_pkg::num_t'(wids_pkg::VIB_WEIGHT) * wids_pkg::num_t'(vtot_q)
					+ wids_pkg::num_t'(wids_pkg::PRES_WEIGHT) * wids_pkg::num_t'(ptot_q);
				if (dtot_q < near_c) begin
					diff_q <= near_c - wids_pkg::near_t'(dtot_q);
				end else begin
					diff_q <= '0;
				end
			end
			wids_pkg::BK_LOAD: begin
				quo_q  <= {num_c[wids_pkg::NUM_W-2:0], 1'b0} + wids_pkg::num_t'(count_c);
				rem_q  <= '0;
				den_q  <= {count_c, 1'b0};
				dcnt_q <= wids_pkg::div_cnt_t'(wids_pkg::NUM_W - 1);
			end
			wids_pkg::BK_DIV: begin
				quo_q  <= {quo_q[wids_pkg::NUM_W-2:0], ge_c};
				rem_q  <= ge_c ? wids_pkg::den_t'(trial_c - {1'b0, den_q})
					: wids_pkg::den_t'(trial_c);
				dcnt_q <= dcnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q       <= '0;
			full_q       <= 1'b0;
			vtot_q       <= '0;
			ptot_q       <= '0;
			dtot_q       <= '0;
			score_q      <= '0;
			res_valid_q  <= 1'b0;
			res_acc_q    <= 1'b0;
			res_score_q  <= '0;
			res_likely_q <= 1'b0;
		end else begin
			if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				wids_pkg::BK_IDLE: begin
					if (pop_valid && pop_ready && !pop_item.accepted) begin
						res_valid_q  <= 1'b1;
						res_acc_q    <= 1'b0;
						res_score_q  <= score_q;
						res_likely_q <= score_q >= threshold;
					end
				end
				wids_pkg::BK_READ: begin
					vtot_q <= vtot_q - wids_pkg::cnt_t'(full_q & old_q.vibration)
						+ wids_pkg::cnt_t'(item_q.vibration);
					ptot_q <= ptot_q - wids_pkg::cnt_t'(full_q & old_q.presence)
						+ wids_pkg::cnt_t'(item_q.presence);
					dtot_q <= dtot_q - (full_q ? wids_pkg::dtot_t'(old_q.distance_mm) : '0)
						+ wids_pkg::dtot_t'(item_q.distance_mm);
					if (slot_q == wids_pkg::slot_t'(wids_pkg::WINDOW_DEPTH - 1)) begin
						slot_q <= '0;
						full_q <= 1'b1;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				wids_pkg::BK_COUNT: begin
					if (count_c < wids_pkg::MIN_COUNT) begin
						score_q      <= '0;
						res_valid_q  <= 1'b1;
						res_acc_q    <= 1'b1;
						res_score_q  <= '0;
						res_likely_q <= threshold == '0;
					end
				end
				wids_pkg::BK_SCORE: begin
					score_q      <= score_new;
					res_valid_q  <= 1'b1;
					res_acc_q    <= 1'b1;
					res_score_q  <= score_new;
					res_likely_q <= score_new >= threshold;
				end
				default: begin
				end
			endcase
		end
	end

	`WIDS_ASSERT_HOLD(a_score_range, clk, arst_n, 1'b1, score_q <= wids_pkg::SCORE_MAX)
	`WIDS_ASSERT_HOLD(a_vib_total, clk, arst_n, 1'b1, vtot_q <= count_c)
	`WIDS_ASSERT_HOLD(a_div_nonzero, clk, arst_n, state_q == wids_pkg::BK_DIV, den_q != '0)
	`WIDS_ASSERT_NEXT(a_score_shown, clk, arst_n, state_q == wids_pkg::BK_SCORE, res_valid_q)

endmodule

// ===== src/windowed_intrusion_damage_scorer_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Windowed intrusion damage scorer
// Rate-limited sample window with a smoothed damage score and alarm flag.
// ============================================================================
// Every sample transaction produces exactly one result transaction. When the
// scorer is idle, a sample that arrives too soon after the last accepted one
// gets its result, with the current score, once it has passed the queue and
// the result register. With the 16-entry window, an accepted sample gets its
// result after it leaves the queue, passes the window and total update
// (BK_READ, BK_COUNT, BK_LOAD), one quotient bit per cycle in the bit-serial
// divider (19 bits here), and the decay rule (BK_SCORE). While fewer than
// five samples are in the window, the score is zero and the result is set in
// BK_COUNT without the divider. The scorer takes the next sample only after
// its result transaction has completed. A two-entry queue lets new samples be
// classified while the scorer works. Configuration writes are always taken;
// the interval applies to later samples and the threshold to later results.
module windowed_intrusion_damage_scorer_core (
	input  logic          clk,
	input  logic          arst_n,
	wids_sample_if.sink   sample,
	wids_result_if.source result,
	wids_cfg_if.sink      cfg
);

	wids_pkg::stamp_t interval_q;
	wids_pkg::score_t threshold_q;

	wids_pkg::item_t  push_item;
	logic             push_valid;
	logic             push_ready;
	wids_pkg::item_t  pop_item;
	logic             pop_valid;
	logic             pop_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= wids_pkg::stamp_t'(wids_pkg::INTERVAL_RESET);
			threshold_q <= wids_pkg::score_t'(wids_pkg::THRESHOLD_RESET);
		end else if (cfg.valid) begin
			case (wids_pkg::cfg_reg_t'(cfg.index))
				wids_pkg::CFG_INTERVAL: begin
					interval_q <= wids_pkg::stamp_t'(cfg.data);
				end
				wids_pkg::CFG_THRESHOLD: begin
					threshold_q <= cfg.data[wids_pkg::SCORE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	wids_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.interval   (interval_q),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	wids_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_item   (pop_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	wids_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_item  (pop_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.threshold (threshold_q),
		.result    (result)
	);

endmodule
